FILE: hw/rtl/jfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the finite-difference Jacobian block.
// No dependencies.

package jfd_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z  = 3'd5;

    localparam logic [5:0]  SIZE_RESET = 6'd32;
    localparam logic [31:0] INV_RESET  = 32'd65536;

    localparam int VOX_W = 96;
    localparam int CRD_W = 6;

    // sequencer steps
    localparam logic [3:0] STEP_RD_LAST = 4'd5;
    localparam logic [3:0] STEP_LAST    = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic       wr_voxel;
        logic       load_q;
        logic       rd_en;
        logic [2:0] rd_sel;     // {axis, lo}
        logic       cap_hi;
        logic       diff_en;
        axis_t      diff_axis;
        logic       mul_en;
        logic       sat_en;
        logic       load_out;
    } jfd_cmd_t;

    typedef struct packed {
        logic pos_err;
        logic out_free;
    } jfd_status_t;

endpackage

FILE: hw/rtl/jfd_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.

module jfd_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32768,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/jfd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for voxel writes and Jacobian queries.
// Depends on jfd_pkg.

module jfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    input  jfd_pkg::jfd_status_t status,
    output logic                in_ready,
    output jfd_pkg::jfd_cmd_t   cmd
);

    jfd_pkg::state_t state_reg, state_next;
    logic [3:0]      step_reg, step_next;
    logic            accept;

    assign accept = in_valid && (state_reg == jfd_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jfd_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            jfd_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (accept && op == jfd_pkg::OP_QUERY)
                begin
                    state_next = status.pos_err ? jfd_pkg::ST_DONE : jfd_pkg::ST_RUN;
                end
            end
            jfd_pkg::ST_RUN:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == jfd_pkg::STEP_LAST)
                begin
                    state_next = jfd_pkg::ST_DONE;
                end
            end
            jfd_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = jfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jfd_pkg::ST_IDLE;
            end
        endcase
    end

    // read k at step k; data registered; hi captured, lo differenced, multiply, scale
    always_comb
    begin
        logic [3:0] s_diff;
        s_diff    = step_reg - 4'd2;
        in_ready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            jfd_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.wr_voxel = accept && (op == jfd_pkg::OP_WRITE);
                cmd.load_q   = accept && (op == jfd_pkg::OP_QUERY);
            end
            jfd_pkg::ST_RUN:
            begin
                cmd.rd_en     = step_reg <= jfd_pkg::STEP_RD_LAST;
                cmd.rd_sel    = step_reg[2:0];
                cmd.cap_hi    = step_reg[0] && (step_reg <= jfd_pkg::STEP_RD_LAST);
                cmd.diff_en   = !step_reg[0] && (step_reg >= 4'd2) && (step_reg <= 4'd6);
                cmd.diff_axis = jfd_pkg::axis_t'(s_diff[2:1]);
                cmd.mul_en    = step_reg[0] && (step_reg >= 4'd3) && (step_reg <= 4'd7);
                cmd.sat_en    = !step_reg[0] && (step_reg >= 4'd4);
            end
            jfd_pkg::ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_diff_after_hi: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.diff_en |-> $past(cmd.cap_hi))
        else $error("difference without captured upper neighbour");

    a_err_skips_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_q && status.pos_err) |=> state_reg == jfd_pkg::ST_DONE)
        else $error("out-of-range query entered the read sequence");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jfd_pkg::ST_RUN && step_reg == jfd_pkg::STEP_LAST)
        |=> state_reg == jfd_pkg::ST_DONE)
        else $error("query sequence did not finish");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_voxel |-> !cmd.rd_en && state_reg == jfd_pkg::ST_IDLE)
        else $error("voxel write collides with a query read");

endmodule

FILE: hw/rtl/jfd_datapath.sv
`timescale 1ns / 1ps
// Configuration registers, neighbour addressing, difference/scale pipeline and
// result registers. Depends on jfd_pkg and jfd_ram.

module jfd_datapath #(
    parameter int MAX_DIM = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [jfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic [4:0]                          pos_x,
    input  logic [4:0]                          pos_y,
    input  logic [4:0]                          pos_z,
    input  logic signed [31:0]                  vec_x,
    input  logic signed [31:0]                  vec_y,
    input  logic signed [31:0]                  vec_z,
    input  jfd_pkg::jfd_cmd_t                   cmd,
    output jfd_pkg::jfd_status_t                status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [31:0]                  res [9],
    output logic                                res_err
);

    localparam int AW    = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int EW    = ($clog2(MAX_DIM + 1) > 6) ? $clog2(MAX_DIM + 1) : 6;
    localparam int CW    = jfd_pkg::CRD_W;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    logic [5:0]  size_reg [3];
    logic [31:0] inv_reg  [3];

    logic [EW-1:0]  eff [3];
    logic [4:0]     pin [3];
    logic [CW-1:0]  hi_c [3];
    logic [CW-1:0]  lo_c [3];
    logic           cen_c [3];
    logic           perr;

    logic [CW-1:0]  pos_q_reg [3];
    logic [CW-1:0]  hi_reg [3];
    logic [CW-1:0]  lo_reg [3];
    logic           cen_reg [3];

    logic [CW-1:0]  rc [3];
    logic [AW-1:0]  rd_addr, wr_addr, addr;
    logic           wr_ok;
    logic [jfd_pkg::VOX_W-1:0] rdata, hi_vox_reg;

    logic signed [32:0] diff_reg [3];
    logic signed [65:0] prod_reg [3];
    jfd_pkg::axis_t     diff_axis_reg, mul_axis_reg;
    logic [31:0]        inv_sel;

    logic signed [31:0] work_reg [9];
    logic               work_err_reg;
    logic signed [31:0] out_reg [9];
    logic               out_err_reg;
    logic               out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                size_reg[k] <= jfd_pkg::SIZE_RESET;
                inv_reg[k]  <= jfd_pkg::INV_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jfd_pkg::CFG_SIZE_X: size_reg[0] <= cfg_data[5:0];
                jfd_pkg::CFG_SIZE_Y: size_reg[1] <= cfg_data[5:0];
                jfd_pkg::CFG_SIZE_Z: size_reg[2] <= cfg_data[5:0];
                jfd_pkg::CFG_INV_X:  inv_reg[0]  <= cfg_data;
                jfd_pkg::CFG_INV_Y:  inv_reg[1]  <= cfg_data;
                jfd_pkg::CFG_INV_Z:  inv_reg[2]  <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;

    always_comb
    begin
        perr = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            eff[k] = EW'(size_reg[k]);
            if (eff[k] < EW'(2))
            begin
                eff[k] = EW'(2);
            end
            if (eff[k] > EW'(MAX_DIM))
            begin
                eff[k] = EW'(MAX_DIM);
            end
            perr     = perr | (EW'(pin[k]) >= eff[k]);
            cen_c[k] = (pin[k] != 5'd0) && (EW'(pin[k]) < eff[k] - EW'(1));
            hi_c[k]  = ((pin[k] == 5'd0) || cen_c[k]) ? CW'(pin[k]) + CW'(1) : CW'(pin[k]);
            lo_c[k]  = (pin[k] == 5'd0) ? CW'(0) : CW'(pin[k]) - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pos_q_reg[k] <= CW'(pin[k]);
                hi_reg[k]    <= hi_c[k];
                lo_reg[k]    <= lo_c[k];
                cen_reg[k]   <= cen_c[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rc[k] = pos_q_reg[k];
            if (k == int'(cmd.rd_sel[2:1]))
            begin
                rc[k] = cmd.rd_sel[0] ? lo_reg[k] : hi_reg[k];
            end
        end
        rd_addr = (AW'(rc[2]) * AW'(MAX_DIM) + AW'(rc[1])) * AW'(MAX_DIM) + AW'(rc[0]);
        wr_addr = (AW'(pos_z) * AW'(MAX_DIM) + AW'(pos_y)) * AW'(MAX_DIM) + AW'(pos_x);
        addr    = cmd.wr_voxel ? wr_addr : rd_addr;
        wr_ok   = (EW'(pos_x) < EW'(MAX_DIM)) && (EW'(pos_y) < EW'(MAX_DIM))
                  && (EW'(pos_z) < EW'(MAX_DIM));
    end

    jfd_ram #(
        .WIDTH (jfd_pkg::VOX_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_voxel && wr_ok),
        .re    (cmd.rd_en),
        .addr  (addr),
        .wdata ({vec_z, vec_y, vec_x}),
        .rdata (rdata)
    );

    always_comb
    begin
        case (diff_axis_reg)
            jfd_pkg::AXIS_X: inv_sel = inv_reg[0];
            jfd_pkg::AXIS_Y: inv_sel = inv_reg[1];
            jfd_pkg::AXIS_Z: inv_sel = inv_reg[2];
            default:         inv_sel = inv_reg[0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_hi)
        begin
            hi_vox_reg <= rdata;
        end
        if (cmd.diff_en)
        begin
            diff_axis_reg <= cmd.diff_axis;
            for (int c = 0; c < 3; c++)
            begin
                diff_reg[c] <= {hi_vox_reg[c*32+31], hi_vox_reg[c*32 +: 32]}
                               - {rdata[c*32+31], rdata[c*32 +: 32]};
            end
        end
        if (cmd.mul_en)
        begin
            mul_axis_reg <= diff_axis_reg;
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= 66'(diff_reg[c] * $signed({1'b0, inv_sel}));
            end
        end
    end

    // floor shift, halved once more for a central difference, then clamp
    always_ff @(posedge clk)
    begin
        logic signed [65:0] q;
        logic               cen;
        if (cmd.load_q)
        begin
            work_err_reg <= perr;
            if (perr)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    work_reg[i] <= '0;
                end
            end
        end
        else if (cmd.sat_en)
        begin
            case (mul_axis_reg)
                jfd_pkg::AXIS_X: cen = cen_reg[0];
                jfd_pkg::AXIS_Y: cen = cen_reg[1];
                jfd_pkg::AXIS_Z: cen = cen_reg[2];
                default:         cen = cen_reg[0];
            endcase
            for (int c = 0; c < 3; c++)
            begin
                q = cen ? (prod_reg[c] >>> 17) : (prod_reg[c] >>> 16);
                if (q > SAT_MAX)
                begin
                    work_reg[int'(mul_axis_reg) * 3 + c] <= 32'sh7fffffff;
                end
                else if (q < SAT_MIN)
                begin
                    work_reg[int'(mul_axis_reg) * 3 + c] <= 32'sh80000000;
                end
                else
                begin
                    work_reg[int'(mul_axis_reg) * 3 + c] <= q[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg     <= work_reg;
            out_err_reg <= work_err_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.pos_err  = perr;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign res             = out_reg;
    assign res_err         = out_err_reg;

endmodule

FILE: hw/rtl/jacobian_finite_difference_3d.sv
`timescale 1ns / 1ps
// Top level of the finite-difference Jacobian block.
// Depends on jfd_pkg, jfd_ctrl, jfd_datapath (with jfd_ram).

// A write request (op 0) stores one Q16.16 vector into the voxel store in the
// cycle it is accepted and produces no result; the next request is taken the
// following cycle. A query request (op 1) runs six neighbour reads from the
// single-port voxel store, one per cycle, then the difference, multiply and
// scale stages that trail the last read, a move of the Jacobian into the output
// register, and the idle state in which the next request is taken. A query
// outside the configured sizes skips the reads: it goes straight to the done
// state, which loads zeros with position_error set into the output register,
// and the next request is taken in the idle state after it. A new result
// stalls the input while the previous one is still unaccepted; a loaded result
// waits in the output register while the next request is taken. The store has
// no reset: only written voxels may be queried. Configuration must be written
// only while the block is idle; the block itself does not enforce this.

module jacobian_finite_difference_3d #(
    parameter int MAX_DIM = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [4:0]                    pos_x,
    input  logic [4:0]                    pos_y,
    input  logic [4:0]                    pos_z,
    input  logic signed [31:0]            vec_x,
    input  logic signed [31:0]            vec_y,
    input  logic signed [31:0]            vec_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            dvx_dx,
    output logic signed [31:0]            dvy_dx,
    output logic signed [31:0]            dvz_dx,
    output logic signed [31:0]            dvx_dy,
    output logic signed [31:0]            dvy_dy,
    output logic signed [31:0]            dvz_dy,
    output logic signed [31:0]            dvx_dz,
    output logic signed [31:0]            dvy_dz,
    output logic signed [31:0]            dvz_dz,
    output logic                          position_error
);

    jfd_pkg::jfd_cmd_t    cmd;
    jfd_pkg::jfd_status_t status;
    logic signed [31:0]   res [9];

    jfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    jfd_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res       (res),
        .res_err   (position_error)
    );

    assign dvx_dx = res[0];
    assign dvy_dx = res[1];
    assign dvz_dx = res[2];
    assign dvx_dy = res[3];
    assign dvy_dy = res[4];
    assign dvz_dy = res[5];
    assign dvx_dz = res[6];
    assign dvy_dz = res[7];
    assign dvz_dz = res[8];

endmodule
